// ----- hdl/bcas_pkg.sv -----
// ----------------------------------------------------------------------------
// BCD clock and alarm setter: shared definitions
// Event codes, button codes, digit limits and the state and item structs
// used by the step logic and the top level.
// ----------------------------------------------------------------------------
package bcas_pkg;

  // Event kind carried in tuser of the input stream.
  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_READING = 2'd1,
    MODE_TIMEOUT = 2'd2,
    MODE_TICK    = 2'd3
  } bcas_mode_e;

  // Button codes of a press event.
  typedef enum logic [1:0] {
    BTN_UP    = 2'd0,
    BTN_RIGHT = 2'd1,
    BTN_LEFT  = 2'd2,
    BTN_DOWN  = 2'd3
  } bcas_button_e;

  // Field selected by the upper cursor bits.
  typedef enum logic [2:0] {
    FLD_CUR_HOURS   = 3'd0,
    FLD_CUR_MINUTES = 3'd1,
    FLD_CUR_SECONDS = 3'd2,
    FLD_ALM_HOURS   = 3'd3,
    FLD_ALM_MINUTES = 3'd4,
    FLD_ALM_SECONDS = 3'd5
  } bcas_field_e;

  // Digit limits.
  localparam logic [3:0] LAST_POS      = 4'd11;
  localparam logic [3:0] UNIT_MAX      = 4'd9;
  localparam logic [2:0] TENS_MAX      = 3'd5;
  localparam logic [3:0] HOUR_UNIT_MAX = 4'd3;
  localparam logic [1:0] HOUR_TENS_MAX = 2'd2;

  // Stream widths.
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 48;

  typedef struct packed {
    logic [5:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
  } bcas_time_t;

  typedef struct packed {
    bcas_time_t  cur;
    bcas_time_t  alm;
    logic [3:0]  cursor;
    logic        editing;
    logic        ringing;
    logic        blank;
    logic [15:0] beeps;
  } bcas_state_t;

  typedef struct packed {
    bcas_mode_e   mode;
    bcas_button_e button;
    bcas_time_t   reading;
  } bcas_item_t;

endpackage

// ----- hdl/bcas_digit_edit.sv -----
// ----------------------------------------------------------------------------
// BCD digit stepper
// Steps the tens or units digit of one BCD hours, minutes or seconds value
// up or down, with 24-hour limits for hours and 59 limits otherwise.
// ----------------------------------------------------------------------------
module bcas_digit_edit
  import bcas_pkg::*;
(
  input  logic [6:0] value_i,    // hours use the low 6 bits
  input  logic       is_hours_i,
  input  logic       up_i,
  input  logic       units_i,
  output logic [6:0] value_o
);

  logic [1:0] hr_hi, hr_hi_n;
  logic [2:0] ms_hi, ms_hi_n;
  logic [3:0] lo, lo_n, unit_top;

  assign hr_hi = value_i[5:4];
  assign ms_hi = value_i[6:4];
  assign lo    = value_i[3:0];

  // The hours units digit tops out at three in the twenties.
  assign unit_top = (is_hours_i && hr_hi == HOUR_TENS_MAX) ? HOUR_UNIT_MAX : UNIT_MAX;

  // Minutes and seconds tens digit wraps in 0..5.
  always_comb begin
    if (up_i) begin
      ms_hi_n = (ms_hi == TENS_MAX) ? 3'd0 : ms_hi + 3'd1;
    end else begin
      ms_hi_n = (ms_hi == 3'd0) ? TENS_MAX : ms_hi - 3'd1;
    end
  end

  // Units digit, and hours tens digit with clamping of the units digit.
  always_comb begin
    hr_hi_n = hr_hi;
    lo_n    = lo;
    if (units_i) begin
      if (up_i) begin
        lo_n = (lo == unit_top) ? 4'd0 : lo + 4'd1;
      end else begin
        lo_n = (lo == 4'd0) ? unit_top : lo - 4'd1;
      end
    end else if (is_hours_i) begin
      if (up_i) begin
        if (hr_hi == 2'd1) begin
          hr_hi_n = HOUR_TENS_MAX;
          if (lo > HOUR_UNIT_MAX) begin
            lo_n = HOUR_UNIT_MAX;
          end
        end else if (hr_hi == HOUR_TENS_MAX) begin
          hr_hi_n = 2'd0;
        end else begin
          hr_hi_n = hr_hi + 2'd1;
        end
      end else begin
        if (hr_hi == 2'd0) begin
          hr_hi_n = HOUR_TENS_MAX;
          if (lo > HOUR_UNIT_MAX) begin
            lo_n = HOUR_UNIT_MAX;
          end
        end else begin
          hr_hi_n = hr_hi - 2'd1;
        end
      end
    end
  end

  // Reassemble the value; the tens step only matters when not on units.
  always_comb begin
    if (is_hours_i) begin
      value_o = {1'b0, hr_hi_n, lo_n};
    end else begin
      value_o = {(units_i ? ms_hi : ms_hi_n), lo_n};
    end
  end

endmodule

// ----- hdl/bcas_step.sv -----
// ----------------------------------------------------------------------------
// BCD clock and alarm setter: event step
// Computes the next state and the clock write request for one event from
// the current state.
// ----------------------------------------------------------------------------
module bcas_step
  import bcas_pkg::*;
(
  input  bcas_state_t state_i,
  input  bcas_item_t  item_i,
  output bcas_state_t state_o,
  output logic        rtc_write_o
);

  bcas_field_e field;
  logic [6:0]  sel_value;
  logic [6:0]  new_value;
  logic        sel_hours;
  logic        same_hm;
  logic [15:0] beeps_inc;

  assign field = bcas_field_e'(state_i.cursor[3:1]);

  // Pick the value under the cursor.
  always_comb begin
    sel_hours = 1'b0;
    sel_value = 7'd0;
    unique case (field)
      FLD_CUR_HOURS: begin
        sel_hours = 1'b1;
        sel_value = {1'b0, state_i.cur.hours};
      end
      FLD_CUR_MINUTES: sel_value = state_i.cur.minutes;
      FLD_CUR_SECONDS: sel_value = state_i.cur.seconds;
      FLD_ALM_HOURS: begin
        sel_hours = 1'b1;
        sel_value = {1'b0, state_i.alm.hours};
      end
      FLD_ALM_MINUTES: sel_value = state_i.alm.minutes;
      FLD_ALM_SECONDS: sel_value = state_i.alm.seconds;
      default: sel_value = 7'd0;
    endcase
  end

  bcas_digit_edit u_digit_edit (
    .value_i    (sel_value),
    .is_hours_i (sel_hours),
    .up_i       (item_i.button == BTN_UP),
    .units_i    (state_i.cursor[0]),
    .value_o    (new_value)
  );

  assign same_hm   = (item_i.reading.hours == state_i.alm.hours) &&
                     (item_i.reading.minutes == state_i.alm.minutes);
  assign beeps_inc = state_i.beeps + 16'd1;

  // Event handling.
  always_comb begin
    state_o     = state_i;
    rtc_write_o = 1'b0;
    unique case (item_i.mode)
      MODE_PRESS: begin
        state_o.ringing = 1'b0;
        if (!state_i.editing) begin
          state_o.editing = 1'b1;
          state_o.cursor  = 4'd0;
        end else if (item_i.button == BTN_UP || item_i.button == BTN_DOWN) begin
          rtc_write_o = 1'b1;
          unique case (field)
            FLD_CUR_HOURS:   state_o.cur.hours   = new_value[5:0];
            FLD_CUR_MINUTES: state_o.cur.minutes = new_value;
            FLD_CUR_SECONDS: state_o.cur.seconds = new_value;
            FLD_ALM_HOURS:   state_o.alm.hours   = new_value[5:0];
            FLD_ALM_MINUTES: state_o.alm.minutes = new_value;
            FLD_ALM_SECONDS: state_o.alm.seconds = new_value;
            default: ;
          endcase
        end else if (item_i.button == BTN_RIGHT) begin
          state_o.cursor = (state_i.cursor >= LAST_POS) ? 4'd0 : state_i.cursor + 4'd1;
        end else begin
          state_o.cursor = (state_i.cursor == 4'd0 || state_i.cursor > LAST_POS) ?
                           LAST_POS : state_i.cursor - 4'd1;
        end
      end
      MODE_READING: begin
        state_o.cur = item_i.reading;
        if (same_hm && item_i.reading.seconds >= state_i.alm.seconds &&
            state_i.beeps == 16'd0) begin
          state_o.ringing = 1'b1;
        end else if (!same_hm) begin
          state_o.beeps   = 16'd0;
          state_o.ringing = 1'b0;
        end
      end
      MODE_TIMEOUT: begin
        state_o.editing = 1'b0;
      end
      MODE_TICK: begin
        if (state_i.ringing) begin
          state_o.beeps = beeps_inc;
          state_o.blank = ~beeps_inc[0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/bcd_clock_alarm_setter.sv -----
// ----------------------------------------------------------------------------
// BCD clock and alarm setter
// Button, clock reading, edit timeout and alarm tick events update the held
// time, the alarm time and the edit and alarm flags; every event gives one
// result beat with the state after it.
// ----------------------------------------------------------------------------
// The block takes one event per clock cycle while the output side is not
// stalled and returns exactly one result beat for each. Each event goes into
// an input register, the next state is worked out combinationally from the
// state register and the registered event, and the result lands in an output
// register; that state update sets the rate. While the output register holds
// an untaken result, the input register can still take one more beat.
module bcd_clock_alarm_setter
  import bcas_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata: button[1:0], hours_bcd[7:2], minutes_bcd[14:8],
  //        seconds_bcd[21:15], zero fill [23:22]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: mode[1:0]
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  // Output stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata: cur_hours[5:0], cur_minutes[12:6], cur_seconds[19:13],
  //        alm_hours[25:20], alm_minutes[32:26], alm_seconds[39:33],
  //        cursor[43:40], editing[44], ringing[45], display_blank[46],
  //        rtc_write[47]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic                in_valid_q;
  bcas_item_t          in_q;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_q;
  bcas_state_t         state_q, state_d;
  logic                rtc_write;
  logic                advance;

  // An event moves on when the output register is free or being emptied.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.mode            <= bcas_mode_e'(s_axis_tuser_i[1:0]);
      in_q.button          <= bcas_button_e'(s_axis_tdata_i[1:0]);
      in_q.reading.hours   <= s_axis_tdata_i[7:2];
      in_q.reading.minutes <= s_axis_tdata_i[14:8];
      in_q.reading.seconds <= s_axis_tdata_i[21:15];
    end
  end

  bcas_step u_step (
    .state_i     (state_q),
    .item_i      (in_q),
    .state_o     (state_d),
    .rtc_write_o (rtc_write)
  );

  // State register, updated once per event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= {rtc_write, state_d.blank, state_d.ringing, state_d.editing,
                state_d.cursor,
                state_d.alm.seconds, state_d.alm.minutes, state_d.alm.hours,
                state_d.cur.seconds, state_d.cur.minutes, state_d.cur.hours};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// ----- verif/bcd_clock_alarm_setter_tb.sv -----
// ----------------------------------------------------------------------------
// BCD clock and alarm setter: self-checking testbench
// Drives press, clock reading, edit timeout and alarm tick events into the
// input stream and predicts every result beat with an independent model of
// the clock, alarm and edit state. Results are checked field by field under
// bursty input traffic, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module bcd_clock_alarm_setter_tb
  import bcas_pkg::*;
();

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned RING_TICKS   = 40;

  // Layout of one result beat, highest field first.
  typedef struct packed {
    logic       rtc_write;
    logic       display_blank;
    logic       ringing;
    logic       editing;
    logic [3:0] cursor;
    logic [6:0] alm_seconds;
    logic [6:0] alm_minutes;
    logic [5:0] alm_hours;
    logic [6:0] cur_seconds;
    logic [6:0] cur_minutes;
    logic [5:0] cur_hours;
  } clock_beat_t;

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [InUserW-1:0]  s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  bcd_clock_alarm_setter dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  // Free-running clock.
  always #5 clk = ~clk;

  // Model of the clock and alarm state.
  bcas_time_t  mdl_cur      = '0;
  bcas_time_t  mdl_alm      = '0;
  logic [3:0]  mdl_cursor   = '0;
  logic        mdl_editing  = 1'b0;
  logic        mdl_ringing  = 1'b0;
  logic        mdl_blank    = 1'b0;
  logic [15:0] mdl_beeps    = '0;

  clock_beat_t expected_beats[$];
  clock_beat_t got_beat;
  clock_beat_t want_beat;

  int unsigned events_sent   = 0;
  int unsigned beats_checked = 0;
  int unsigned mismatches    = 0;
  int unsigned digit_edits   = 0;
  int unsigned alarm_starts  = 0;
  int unsigned ringing_ticks = 0;
  int unsigned cycle_count   = 0;

  // Sender burst control, owned by the stimulus process.
  bit          gaps_on    = 1'b1;
  int unsigned burst_left = 0;

  // Receiver hold-off request: a new token value starts one long stall.
  int unsigned hold_token = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned rx_style   = 0;
  int unsigned rx_cycle   = 0;

  // Step one digit within [0, top], wrapping both ways; out-of-range digits
  // simply move by one under the digit's own bit mask.
  function automatic logic [3:0] roll_digit(logic [3:0] d, logic up, logic [3:0] top,
                                            logic [3:0] dmask);
    if (up) begin
      return (d == top) ? 4'd0 : ((d + 4'd1) & dmask);
    end
    return (d == 4'd0) ? top : ((d - 4'd1) & dmask);
  endfunction

  // Minutes or seconds: tens in 0..5, units in 0..9.
  function automatic logic [6:0] bump_min_sec(logic [6:0] v, logic up, logic units);
    logic [3:0] hi;
    logic [3:0] lo;
    hi = {1'b0, v[6:4]};
    lo = v[3:0];
    if (units) begin
      lo = roll_digit(lo, up, UNIT_MAX, 4'hF);
    end else begin
      hi = roll_digit(hi, up, {1'b0, TENS_MAX}, 4'h7);
    end
    return {hi[2:0], lo};
  endfunction

  // Hours: the tens digit steps through 0, 1, 2 and clamps the units digit
  // to 3 whenever it lands on 2 from below or from 0 going down.
  function automatic logic [5:0] bump_hours(logic [5:0] v, logic up, logic units);
    logic [1:0] hi;
    logic [3:0] lo;
    hi = v[5:4];
    lo = v[3:0];
    if (units) begin
      lo = roll_digit(lo, up, (hi == 2'd2) ? HOUR_UNIT_MAX : UNIT_MAX, 4'hF);
    end else if (up) begin
      if (hi == 2'd1) begin
        hi = 2'd2;
        if (lo > HOUR_UNIT_MAX) lo = HOUR_UNIT_MAX;
      end else if (hi == 2'd2) begin
        hi = 2'd0;
      end else begin
        hi = hi + 2'd1;
      end
    end else begin
      if (hi == 2'd0) begin
        hi = 2'd2;
        if (lo > HOUR_UNIT_MAX) lo = HOUR_UNIT_MAX;
      end else begin
        hi = hi - 2'd1;
      end
    end
    return {hi, lo};
  endfunction

  // Apply an up or down press to the digit under the cursor.
  function automatic void edit_selected_digit(logic up);
    logic units;
    units = mdl_cursor[0];
    case (bcas_field_e'(mdl_cursor[3:1]))
      FLD_CUR_HOURS:   mdl_cur.hours   = bump_hours(mdl_cur.hours, up, units);
      FLD_CUR_MINUTES: mdl_cur.minutes = bump_min_sec(mdl_cur.minutes, up, units);
      FLD_CUR_SECONDS: mdl_cur.seconds = bump_min_sec(mdl_cur.seconds, up, units);
      FLD_ALM_HOURS:   mdl_alm.hours   = bump_hours(mdl_alm.hours, up, units);
      FLD_ALM_MINUTES: mdl_alm.minutes = bump_min_sec(mdl_alm.minutes, up, units);
      FLD_ALM_SECONDS: mdl_alm.seconds = bump_min_sec(mdl_alm.seconds, up, units);
      default: ;
    endcase
  endfunction

  // Advance the model by one event and return the beat it must produce.
  function automatic clock_beat_t clock_model_step(bcas_mode_e md, bcas_button_e bt,
                                                   bcas_time_t rd);
    clock_beat_t r;
    logic        wr;
    logic        same;
    wr = 1'b0;
    case (md)
      MODE_PRESS: begin
        mdl_ringing = 1'b0;
        if (!mdl_editing) begin
          mdl_editing = 1'b1;
          mdl_cursor  = 4'd0;
        end else if (bt == BTN_UP || bt == BTN_DOWN) begin
          edit_selected_digit(bt == BTN_UP);
          wr = 1'b1;
          digit_edits++;
        end else if (bt == BTN_RIGHT) begin
          mdl_cursor = (mdl_cursor >= LAST_POS) ? 4'd0 : mdl_cursor + 4'd1;
        end else begin
          mdl_cursor = (mdl_cursor == 4'd0 || mdl_cursor > LAST_POS) ? LAST_POS
                                                                     : mdl_cursor - 4'd1;
        end
      end
      MODE_READING: begin
        mdl_cur = rd;
        same = (mdl_cur.hours == mdl_alm.hours) && (mdl_cur.minutes == mdl_alm.minutes);
        if (same && mdl_cur.seconds >= mdl_alm.seconds && mdl_beeps == 16'd0) begin
          if (!mdl_ringing) alarm_starts++;
          mdl_ringing = 1'b1;
        end else if (!same) begin
          mdl_beeps   = 16'd0;
          mdl_ringing = 1'b0;
        end
      end
      MODE_TIMEOUT: begin
        mdl_editing = 1'b0;
      end
      default: begin
        if (mdl_ringing) begin
          mdl_beeps = mdl_beeps + 16'd1;
          mdl_blank = ~mdl_beeps[0];
          ringing_ticks++;
        end
      end
    endcase
    r.cur_hours     = mdl_cur.hours;
    r.cur_minutes   = mdl_cur.minutes;
    r.cur_seconds   = mdl_cur.seconds;
    r.alm_hours     = mdl_alm.hours;
    r.alm_minutes   = mdl_alm.minutes;
    r.alm_seconds   = mdl_alm.seconds;
    r.cursor        = mdl_cursor;
    r.editing       = mdl_editing;
    r.ringing       = mdl_ringing;
    r.display_blank = mdl_blank;
    r.rtc_write     = wr;
    return r;
  endfunction

  // Offer one event beat, honoring the burst pattern, and record its
  // expected result once the beat is taken.
  task automatic send_event(bcas_mode_e md, bcas_button_e bt, logic [5:0] hh,
                            logic [6:0] mm, logic [6:0] ss);
    int unsigned gap;
    bcas_time_t  rd;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(8, 30);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    rd.hours   = hh;
    rd.minutes = mm;
    rd.seconds = ss;
    s_tvalid <= 1'b1;
    s_tuser  <= md;
    s_tdata  <= {2'b00, ss, mm, hh, bt};
    do @(posedge clk); while (!s_tready);
    expected_beats.push_back(clock_model_step(md, bt, rd));
    events_sent++;
  endtask

  function automatic bcas_button_e any_button();
    return bcas_button_e'($urandom_range(0, 3));
  endfunction

  // Event helpers; fields the event does not use carry random bits.
  task automatic press(bcas_button_e bt);
    send_event(MODE_PRESS, bt, 6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)),
               7'($urandom_range(0, 127)));
  endtask

  task automatic reading(logic [5:0] hh, logic [6:0] mm, logic [6:0] ss);
    send_event(MODE_READING, any_button(), hh, mm, ss);
  endtask

  task automatic timeout_ev();
    send_event(MODE_TIMEOUT, any_button(), 6'($urandom_range(0, 63)),
               7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
  endtask

  task automatic tick_ev();
    send_event(MODE_TICK, any_button(), 6'($urandom_range(0, 63)),
               7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
  endtask

  task automatic noise_ev();
    send_event(bcas_mode_e'($urandom_range(0, 3)), any_button(),
               6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)),
               7'($urandom_range(0, 127)));
  endtask

  // Up and down are favored so that digits change often.
  function automatic bcas_button_e edit_button();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return BTN_UP;
    if (pick < 6) return BTN_DOWN;
    if (pick < 8) return BTN_RIGHT;
    return BTN_LEFT;
  endfunction

  // First press enters edit mode; the cursor wraps in both directions.
  task automatic test_edit_entry();
    press(BTN_DOWN);
    press(BTN_LEFT);
    press(BTN_RIGHT);
  endtask

  // Hours tens and units limits, clamping and out-of-range digits.
  task automatic test_hours_digits();
    reading(6'h19, 7'h7F, 7'h7F);
    press(BTN_UP);
    press(BTN_UP);
    reading(6'h08, 7'h7F, 7'h7F);
    press(BTN_DOWN);
    press(BTN_RIGHT);
    press(BTN_UP);
    reading(6'h3F, 7'h7F, 7'h7F);
    press(BTN_UP);
  endtask

  // Minutes tens and units that start out of range.
  task automatic test_minute_digits();
    press(BTN_RIGHT);
    press(BTN_UP);
    press(BTN_RIGHT);
    press(BTN_UP);
  endtask

  // Edit an alarm digit, then ring, beep, stop and clear the beep count.
  task automatic test_alarm_basics();
    timeout_ev();
    press(BTN_UP);
    press(BTN_LEFT);
    press(BTN_UP);
    reading(6'h00, 7'h00, 7'h00);
    reading(6'h00, 7'h00, 7'h01);
    tick_ev();
    tick_ev();
    press(BTN_LEFT);
    tick_ev();
    reading(6'h00, 7'h00, 7'h05);
    reading(6'h00, 7'h01, 7'h00);
  endtask

  // Random editing sessions with timeouts and stray readings.
  task automatic test_random_editing(int unsigned n);
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        timeout_ev();
      end else if (pick < 11) begin
        reading(6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)));
      end else if (pick < 13) begin
        tick_ev();
      end else begin
        press(edit_button());
      end
    end
  endtask

  // Readings aimed at the alarm time, beeping, stopping and alarm edits.
  task automatic test_random_alarm(int unsigned n);
    int unsigned pick;
    int unsigned k;
    int unsigned start;
    start = events_sent;
    while (events_sent < start + n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        reading(mdl_alm.hours, mdl_alm.minutes,
                $urandom_range(0, 1) ? 7'($urandom_range(mdl_alm.seconds, 127))
                                     : 7'($urandom_range(0, 127)));
        k = $urandom_range(0, 6);
        repeat (k) tick_ev();
        if ($urandom_range(0, 1)) begin
          press(any_button());
        end else begin
          reading(mdl_alm.hours,
                  $urandom_range(0, 1) ? mdl_alm.minutes : 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)));
        end
      end else if (pick < 70) begin
        timeout_ev();
        press(any_button());
        k = $urandom_range(1, 6);
        repeat (k) press(BTN_LEFT);
        k = $urandom_range(1, 5);
        repeat (k) press($urandom_range(0, 1) ? BTN_UP : BTN_DOWN);
      end else begin
        noise_ev();
      end
    end
  endtask

  // Ring and tick back to back for a long stretch, then stop the alarm.
  task automatic test_long_ring();
    reading(mdl_alm.hours, mdl_alm.minutes ^ 7'h01, 7'h00);
    reading(mdl_alm.hours, mdl_alm.minutes, 7'h7F);
    gaps_on = 1'b0;
    repeat (RING_TICKS) tick_ev();
    gaps_on = 1'b1;
    reading(mdl_alm.hours, mdl_alm.minutes, 7'h7F);
    press(any_button());
    reading(mdl_alm.hours, mdl_alm.minutes, 7'h7F);
  endtask

  // The receiver holds off for a long stretch while events keep coming.
  task automatic test_input_stall(int unsigned n);
    gaps_on = 1'b0;
    hold_token <= hold_token + 1;
    repeat (n) noise_ev();
    gaps_on = 1'b1;
  endtask

  // Receiver ready pattern: style is re-picked when rx_cycle[6:0] is zero; a
  // new hold token forces a long stall counted here.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[6:0] == 7'd0) rx_style <= $urandom_range(0, 2);
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      case (rx_style)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ((rx_cycle % 7) < 4);
      endcase
    end
  end

  task automatic compare_field(string fname, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("Mismatch in beat %0d, %s: expected 0x%0h, got 0x%0h",
                 beats_checked, fname, want_v, got_v);
      end
    end
  endtask

  // Check every result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      got_beat = clock_beat_t'(m_tdata);
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("Result beat 0x%h arrived with no prediction pending", m_tdata);
        end
      end else begin
        want_beat = expected_beats.pop_front();
        compare_field("cur_hours", 32'(want_beat.cur_hours), 32'(got_beat.cur_hours));
        compare_field("cur_minutes", 32'(want_beat.cur_minutes),
                      32'(got_beat.cur_minutes));
        compare_field("cur_seconds", 32'(want_beat.cur_seconds),
                      32'(got_beat.cur_seconds));
        compare_field("alm_hours", 32'(want_beat.alm_hours), 32'(got_beat.alm_hours));
        compare_field("alm_minutes", 32'(want_beat.alm_minutes),
                      32'(got_beat.alm_minutes));
        compare_field("alm_seconds", 32'(want_beat.alm_seconds),
                      32'(got_beat.alm_seconds));
        compare_field("cursor", 32'(want_beat.cursor), 32'(got_beat.cursor));
        compare_field("editing", 32'(want_beat.editing), 32'(got_beat.editing));
        compare_field("ringing", 32'(want_beat.ringing), 32'(got_beat.ringing));
        compare_field("display_blank", 32'(want_beat.display_blank),
                      32'(got_beat.display_blank));
        compare_field("rtc_write", 32'(want_beat.rtc_write), 32'(got_beat.rtc_write));
      end
      beats_checked++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d beats outstanding",
               cycle_count, expected_beats.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edit_entry();
    test_hours_digits();
    test_minute_digits();
    test_alarm_basics();
    test_random_editing(400);
    test_random_alarm(450);
    test_input_stall(150);
    test_long_ring();
    test_random_editing(80);

    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d events and %0d result beats: %0d digit edits, %0d alarm starts,",
             events_sent, beats_checked, digit_edits, alarm_starts);
    $display("%0d beeps while ringing including one long back-to-back ring, and a %0d-cycle hold-off.",
             ringing_ticks, HOLD_CYCLES);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
